FILE: hw/rtl/natural_log_multiplicative_normalization_macros.svh
// Assertion macros for the natural log block.
// Included by the top level; needs nothing else.
`ifndef NATURAL_LOG_MULTIPLICATIVE_NORMALIZATION_MACROS_SVH
`define NATURAL_LOG_MULTIPLICATIVE_NORMALIZATION_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NLMN_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NLMN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/nlmn_pkg.sv
// Shared types, widths and the factor-log table for the natural log block.
// Used by the controller, the datapath and the top level; depends on nothing.
package nlmn_pkg;

  localparam int X_W        = 32;
  localparam int LN_W       = 32;
  localparam int STEPS_W    = 6;
  localparam int THR_W      = 27;
  localparam int LOG_FRAC   = 26;
  localparam int LOG_W      = 29;  // ln(256) in Q.26 is below 2**29
  localparam int ACC_W      = 37;  // room for 64 steps of ln(256) below 8*ln2
  localparam int ROM_DEPTH  = 64;
  localparam int ROM_IDX_W  = 6;
  localparam int SHIFT_FACTORS = 4;

  localparam int TABLE_ENTRIES_DEF     = 52;
  localparam int RESIDUE_FRAC_BITS_DEF = 48;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(671089);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } nlmn_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic step_done;
  } nlmn_sts_t;

  typedef logic [ROM_DEPTH-1:0][LOG_W-1:0] log_rom_t;

  // floor(2**m / k) by restoring division; evaluated only at elaboration.
  function automatic logic [63:0] div_pow2(int unsigned m, int unsigned k);
    logic [63:0] q;
    logic [63:0] rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], (b == int'(m))};
      if (rem >= 64'(k)) begin
        rem  = rem - 64'(k);
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // ln(1 + 2**-n) in Q.60 by its alternating series.
  function automatic logic [63:0] ln1p_q60(int unsigned n);
    logic [63:0] acc;
    logic [63:0] t;
    acc = '0;
    for (int unsigned k = 1; k <= 60; k++) begin
      if (k * n <= 60) begin
        t = div_pow2(60 - k * n, k);
        if (k[0]) begin
          acc = acc + t;
        end else begin
          acc = acc - t;
        end
      end
    end
    return acc;
  endfunction

  // Factor logs in Q.26, rounded to nearest: 256, 16, 4, 2, then 1 + 2**-n.
  function automatic log_rom_t build_log_rom();
    log_rom_t    rom;
    logic [63:0] ln2;
    logic [63:0] v;
    ln2 = ln1p_q60(1);
    for (int i = 0; i < ROM_DEPTH; i++) begin
      if (i < SHIFT_FACTORS) begin
        v = (64'd8 >> i) * ln2;
      end else begin
        v = ln1p_q60(i - 3);
      end
      rom[i] = LOG_W'((v + (64'd1 << 33)) >> 34);
    end
    return rom;
  endfunction

  localparam log_rom_t LOG_ROM = build_log_rom();

endpackage

FILE: hw/rtl/nlmn_ctrl.sv
// Sequencer for the natural log block: load, normalization steps, result.
// Depends on nlmn_pkg for the command and status structs.
module nlmn_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  nlmn_pkg::nlmn_sts_t sts,
  output nlmn_pkg::nlmn_cmd_t cmd
);
  import nlmn_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       out_free;

  // The result register can be written when empty or being emptied.
  assign out_free = !out_valid_r || out_ready;

  // Next state and commands.
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.step = 1'b1;
        if (sts.step_done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result valid flag.
  always_comb begin
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: hw/rtl/nlmn_dpath.sv
// Datapath of the natural log block: residue, log accumulator, factor search,
// final correction and the result register. Depends on nlmn_pkg.
module nlmn_dpath #(
  parameter int TABLE_ENTRIES     = nlmn_pkg::TABLE_ENTRIES_DEF,
  parameter int RESIDUE_FRAC_BITS = nlmn_pkg::RESIDUE_FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [nlmn_pkg::THR_W-1:0]  cfg_wr_data,
  input  logic [nlmn_pkg::X_W-1:0]    x_value,
  input  nlmn_pkg::nlmn_cmd_t         cmd,
  output nlmn_pkg::nlmn_sts_t         sts,
  output logic signed [nlmn_pkg::LN_W-1:0] ln_value,
  output logic                        zero_input,
  output logic [nlmn_pkg::STEPS_W-1:0] steps_used
);
  import nlmn_pkg::*;

  localparam int RF    = RESIDUE_FRAC_BITS;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  logic [THR_W-1:0]   thr_r;
  logic [RF-1:0]      res_r, res_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [CNT_W-1:0]   fi_r, fi_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               zero_r, zero_nxt;
  logic [LN_W-1:0]    ln_r;
  logic               zflag_r;
  logic [STEPS_W-1:0] steps_r;

  logic [RF+31:0]       x_ext;
  logic [ROM_IDX_W-1:0] rom_idx;
  logic [LOG_W-1:0]     lk_rom;
  logic [LOG_W-1:0]     lk;
  logic                 exhausted;
  logic                 is_shift;
  logic                 shift_fit;
  logic [RF-1:0]        shift_prod;
  logic [5:0]           add_n;
  logic [RF:0]          add_sum;
  logic                 fit;
  logic                 taken;
  logic [CNT_W-1:0]     cnt_inc;
  logic                 stop;

  // Operand scaled by 1/256: x as a fraction with RF bits.
  assign x_ext = {x_value, RF'(0)};

  // Factor log lookup for the current candidate.
  assign rom_idx = ROM_IDX_W'(fi_r);
  assign lk_rom  = LOG_ROM[rom_idx];

  assign exhausted = (fi_r == CNT_W'(TABLE_ENTRIES));
  assign is_shift  = (fi_r < CNT_W'(SHIFT_FACTORS));

  // Power-of-two factors: 256, 16, 4 and 2 fit while the top bits are clear.
  always_comb begin
    case (fi_r[1:0])
      2'd0: begin
        shift_fit  = (res_r[RF-1 -: 8] == '0);
        shift_prod = res_r << 8;
      end
      2'd1: begin
        shift_fit  = (res_r[RF-1 -: 4] == '0);
        shift_prod = res_r << 4;
      end
      2'd2: begin
        shift_fit  = (res_r[RF-1 -: 2] == '0);
        shift_prod = res_r << 2;
      end
      default: begin
        shift_fit  = !res_r[RF-1];
        shift_prod = res_r << 1;
      end
    endcase
  end

  // Factor 1 + 2**-n: truncated shift-and-add, fits while below one.
  assign add_n   = 6'(fi_r - CNT_W'(3));
  assign add_sum = {1'b0, res_r} + {1'b0, res_r >> add_n};

  assign fit   = !exhausted && (is_shift ? shift_fit : !add_sum[RF]);
  assign lk    = fit ? lk_rom : '0;
  assign taken = fit || exhausted;

  // A taken step ends the run on a small log or on the last step.
  assign cnt_inc = cnt_r + CNT_W'(1);
  assign stop    = (lk < LOG_W'(thr_r)) || (cnt_inc == CNT_W'(TABLE_ENTRIES));
  assign sts.step_done = zero_r || (taken && stop);

  // Iteration state update.
  always_comb begin
    res_nxt  = res_r;
    acc_nxt  = acc_r;
    fi_nxt   = fi_r;
    cnt_nxt  = cnt_r;
    zero_nxt = zero_r;
    if (cmd.load) begin
      res_nxt  = x_ext[RF+31:32];
      acc_nxt  = ACC_W'(LOG_ROM[0]);
      fi_nxt   = '0;
      cnt_nxt  = '0;
      zero_nxt = (x_value == '0);
    end else if (cmd.step && !zero_r) begin
      if (taken) begin
        if (fit) begin
          res_nxt = is_shift ? shift_prod : add_sum[RF-1:0];
        end
        acc_nxt = acc_r - ACC_W'(lk);
        cnt_nxt = cnt_inc;
      end else begin
        fi_nxt = fi_r + CNT_W'(1);
      end
    end
  end

  // Final correction: subtract (1 - r) rounded into Q.26.
  logic [RF:0]      one_minus_r;
  logic [ACC_W-1:0] dq;
  logic [ACC_W-1:0] diff;
  logic [ACC_W-LN_W:0] diff_top;
  logic [LN_W-1:0]  ln_sat;
  logic [STEPS_W-1:0] steps_sat;

  assign one_minus_r = ((RF+1)'(1) << RF) - {1'b0, res_r};

  if (RF > LOG_FRAC) begin : g_round
    localparam logic [RF:0] RND = (RF+1)'(1) << (RF - LOG_FRAC - 1);
    logic [RF:0] rounded;
    assign rounded = one_minus_r + RND;
    assign dq      = ACC_W'(rounded >> (RF - LOG_FRAC));
  end else begin : g_widen
    assign dq = ACC_W'(one_minus_r) << (LOG_FRAC - RF);
  end

  assign diff     = acc_r - dq;
  assign diff_top = diff[ACC_W-1:LN_W-1];

  // Saturate to the signed 32-bit range.
  always_comb begin
    if ((&diff_top) || !(|diff_top)) begin
      ln_sat = diff[LN_W-1:0];
    end else if (diff[ACC_W-1]) begin
      ln_sat = {1'b1, {(LN_W-1){1'b0}}};
    end else begin
      ln_sat = {1'b0, {(LN_W-1){1'b1}}};
    end
  end

  assign steps_sat = (7'(cnt_r) > 7'd63) ? {STEPS_W{1'b1}} : STEPS_W'(cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= THR_RESET;
      res_r  <= '0;
      acc_r  <= '0;
      fi_r   <= '0;
      cnt_r  <= '0;
      zero_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        thr_r <= cfg_wr_data;
      end
      res_r  <= res_nxt;
      acc_r  <= acc_nxt;
      fi_r   <= fi_nxt;
      cnt_r  <= cnt_nxt;
      zero_r <= zero_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      ln_r    <= zero_r ? '0 : ln_sat;
      zflag_r <= zero_r;
      steps_r <= zero_r ? '0 : steps_sat;
    end
  end

  assign ln_value   = $signed(ln_r);
  assign zero_input = zflag_r;
  assign steps_used = steps_r;

endmodule

FILE: hw/rtl/natural_log_multiplicative_normalization.sv
// Natural logarithm by multiplicative normalization. One word in: x_value in
// unsigned Q8.24; one word out: ln_value in signed Q5.26, a zero_input flag and
// the number of steps used. A single shift-and-add unit tests one table factor
// per cycle and the factor search resumes where the previous step left off; the
// result is stored once the steps are done and the result register is free, so a
// full result register holds back the store until it is read. One word is in
// work at a time; the result register lets the next word enter while the previous
// result waits. stop_threshold is written through cfg_wr_en/cfg_wr_data.
`include "natural_log_multiplicative_normalization_macros.svh"

module natural_log_multiplicative_normalization #(
  parameter int TABLE_ENTRIES     = nlmn_pkg::TABLE_ENTRIES_DEF,
  parameter int RESIDUE_FRAC_BITS = nlmn_pkg::RESIDUE_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [nlmn_pkg::THR_W-1:0]        cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [nlmn_pkg::X_W-1:0]          in_x_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [nlmn_pkg::LN_W-1:0]  out_ln_value,
  output logic                              out_zero_input,
  output logic [nlmn_pkg::STEPS_W-1:0]      out_steps_used
);
  import nlmn_pkg::*;

  nlmn_cmd_t cmd;
  nlmn_sts_t sts;

  // Sequencer.
  nlmn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Arithmetic and result register.
  nlmn_dpath #(
    .TABLE_ENTRIES     (TABLE_ENTRIES),
    .RESIDUE_FRAC_BITS (RESIDUE_FRAC_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .x_value     (in_x_value),
    .cmd         (cmd),
    .sts         (sts),
    .ln_value    (out_ln_value),
    .zero_input  (out_zero_input),
    .steps_used  (out_steps_used)
  );

  // An accepted word blocks the input until its result is stored.
  `NLMN_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready,
                    "input taken while busy")

  // The result register is never overwritten while a result is still held.
  `NLMN_ASSERT_IMPLIES(a_finish_when_free, clk, rst_n, cmd.finish, !out_valid || out_ready,
                       "result overwritten")

  // A zero operand gives a zero log and no steps.
  `NLMN_ASSERT_IMPLIES(a_zero_result, clk, rst_n, out_valid && out_zero_input,
                       out_ln_value == '0 && out_steps_used == '0, "bad zero result")

  // The step count never exceeds the table length.
  `NLMN_ASSERT_IMPLIES(a_steps_bound, clk, rst_n, out_valid,
                       7'(out_steps_used) <= 7'(TABLE_ENTRIES), "step count too large")

endmodule

FILE: dv/nlmn_ln_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the natural log block. It watches the config, input and result
// ports, predicts ln(x) for each accepted word, and compares field by field.
// Depends on nlmn_pkg for the port widths and the threshold reset value.
module nlmn_ln_checker #(
  parameter int TABLE_ENTRIES     = nlmn_pkg::TABLE_ENTRIES_DEF,
  parameter int RESIDUE_FRAC_BITS = nlmn_pkg::RESIDUE_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [nlmn_pkg::THR_W-1:0]        cfg_wr_data,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [nlmn_pkg::X_W-1:0]          in_x_value,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic signed [nlmn_pkg::LN_W-1:0]  out_ln_value,
  input  logic                              out_zero_input,
  input  logic [nlmn_pkg::STEPS_W-1:0]      out_steps_used,
  output int                                mismatch_count,
  output int                                words_in_flight
);

  localparam int REPORT_LIMIT = 10;
  localparam longint unsigned RES_ONE = 64'd1 << RESIDUE_FRAC_BITS;
  localparam int LOG_SHIFT = RESIDUE_FRAC_BITS - nlmn_pkg::LOG_FRAC;

  typedef struct packed {
    logic signed [nlmn_pkg::LN_W-1:0] ln_value;
    logic                             zero_input;
    logic [nlmn_pkg::STEPS_W-1:0]     steps_used;
  } ln_word_t;

  longint unsigned          factor_log [64];
  logic [nlmn_pkg::THR_W-1:0] stop_thr;
  ln_word_t                 ln_expected_q [$];

  // ln(1 + 2^-n) in Q.60 from the alternating series.
  function automatic longint unsigned ln1p_fixed60(int unsigned n);
    longint unsigned sum;
    longint unsigned term;
    int unsigned     k;
    sum = 0;
    for (k = 1; k * n <= 60; k++) begin
      term = (64'd1 << (60 - k * n)) / k;
      if (k % 2 == 1) sum = sum + term;
      else sum = sum - term;
    end
    return sum;
  endfunction

  // Factor logs in Q.26, rounded to nearest: 256, 16, 4, 2, then 1 + 2^-n.
  initial begin
    longint unsigned ln2_q60;
    longint unsigned v;
    ln2_q60 = ln1p_fixed60(1);
    for (int i = 0; i < 64; i++) begin
      if (i < 4) begin
        v = 64'(8 >> i) * ln2_q60;
        factor_log[i] = (v + (64'd1 << 33)) >> 34;
      end else if (i - 3 <= 60) begin
        v = ln1p_fixed60(i - 3);
        factor_log[i] = (v + (64'd1 << 33)) >> 34;
      end else begin
        factor_log[i] = 0;
      end
    end
  end

  // Normalize the residue toward one and accumulate the removed logs.
  function automatic ln_word_t predict_ln(logic [nlmn_pkg::X_W-1:0] x,
                                          logic [nlmn_pkg::THR_W-1:0] thr);
    ln_word_t        res;
    longint unsigned r;
    longint unsigned prod;
    longint unsigned cand;
    longint unsigned step_log;
    longint unsigned corr;
    longint          acc;
    longint          val;
    int unsigned     steps;
    int unsigned     idx;
    int unsigned     n;
    bit              fits;
    res = '0;
    if (x == '0) begin
      res.zero_input = 1'b1;
      return res;
    end
    if (RESIDUE_FRAC_BITS >= 32) r = 64'(x) << (RESIDUE_FRAC_BITS - 32);
    else r = 64'(x) >> (32 - RESIDUE_FRAC_BITS);
    acc   = longint'(factor_log[0]);
    steps = 0;
    for (int t = 0; t < TABLE_ENTRIES && t < 64; t++) begin
      step_log = 0;
      prod     = r;
      // The first factor whose product stays below one wins.
      for (idx = 0; idx < TABLE_ENTRIES && idx < 64; idx++) begin
        if (idx < 4) begin
          fits = r < (RES_ONE >> (8 >> idx));
          cand = r << (8 >> idx);
        end else begin
          n    = idx - 3;
          cand = r + ((n < 64) ? (r >> n) : 64'd0);
          fits = cand < RES_ONE;
        end
        if (fits) begin
          prod     = cand;
          step_log = factor_log[idx];
          break;
        end
      end
      r     = prod;
      acc   = acc - longint'(step_log);
      steps = steps + 1;
      if (step_log < 64'(thr)) break;
    end
    // Final correction: subtract (1 - r), rounded into Q.26.
    corr = RES_ONE - r;
    if (LOG_SHIFT > 0) corr = (corr + (64'd1 << (LOG_SHIFT - 1))) >> LOG_SHIFT;
    else corr = corr << (-LOG_SHIFT);
    val  = acc - longint'(corr);
    if (val > 64'sd2147483647) val = 64'sd2147483647;
    if (val < -64'sd2147483648) val = -64'sd2147483648;
    res.ln_value   = val[nlmn_pkg::LN_W-1:0];
    res.steps_used = (steps > 63) ? 6'd63 : steps[nlmn_pkg::STEPS_W-1:0];
    return res;
  endfunction

  // Track the threshold, queue predictions, and check each result word.
  always @(posedge clk) begin
    ln_word_t want;
    ln_word_t got;
    if (!rst_n) begin
      stop_thr = nlmn_pkg::THR_RESET;
      ln_expected_q.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_wr_en) stop_thr = cfg_wr_data;
      if (in_valid && in_ready)
        ln_expected_q = {ln_expected_q, predict_ln(in_x_value, stop_thr)};
      if (out_valid && out_ready) begin
        got = '{out_ln_value, out_zero_input, out_steps_used};
        if (ln_expected_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: result word with nothing expected: ln %0d zero %0b steps %0d",
                     $realtime, got.ln_value, got.zero_input, got.steps_used);
        end else begin
          want = ln_expected_q.pop_front();
          if (got.ln_value !== want.ln_value || got.zero_input !== want.zero_input ||
              got.steps_used !== want.steps_used) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
              $display("%0t: expected ln %0d zero %0b steps %0d, got ln %0d zero %0b steps %0d",
                       $realtime, want.ln_value, want.zero_input, want.steps_used,
                       got.ln_value, got.zero_input, got.steps_used);
          end
        end
      end
    end
    words_in_flight = ln_expected_q.size();
  end

endmodule

FILE: dv/tb_natural_log_multiplicative_normalization.sv
`timescale 1ns / 100ps
// Testbench top for the natural log block: clock, reset, operand and threshold
// stimulus, result back-pressure and the verdict. Needs nlmn_pkg, the block and
// nlmn_ln_checker, which does all prediction and comparison.
module tb_natural_log_multiplicative_normalization;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int LONG_HOLD     = 300;
  localparam int DRAIN_CYCLES  = 120;
  localparam int WORDS_PER_SET = 72;

  typedef enum int {
    SHAPE_ANY, SHAPE_SMALL, SHAPE_NEAR_ONE, SHAPE_ZERO, SHAPE_ONE_HOT,
    SHAPE_NEAR_MAX, SHAPE_ONE_FLIP
  } x_shape_t;

  logic                             clk;
  logic                             rst_n;
  logic                             cfg_wr_en;
  logic [nlmn_pkg::THR_W-1:0]       cfg_wr_data;
  logic                             in_valid;
  logic                             in_ready;
  logic [nlmn_pkg::X_W-1:0]         in_x_value;
  logic                             out_valid;
  logic                             out_ready;
  logic signed [nlmn_pkg::LN_W-1:0] out_ln_value;
  logic                             out_zero_input;
  logic [nlmn_pkg::STEPS_W-1:0]     out_steps_used;
  int                               mismatch_count;
  int                               words_in_flight;
  int                               cycle_count;
  logic                             word_taken;

  natural_log_multiplicative_normalization u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_x_value     (in_x_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_ln_value   (out_ln_value),
    .out_zero_input (out_zero_input),
    .out_steps_used (out_steps_used)
  );

  nlmn_ln_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_x_value      (in_x_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_ln_value    (out_ln_value),
    .out_zero_input  (out_zero_input),
    .out_steps_used  (out_steps_used),
    .mismatch_count  (mismatch_count),
    .words_in_flight (words_in_flight)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Input acceptance seen at the rising edge, read by the driver at the falling one.
  always @(posedge clk) word_taken <= in_valid && in_ready;

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Operand generator, weighted toward the edges of the Q8.24 range.
  function automatic logic [31:0] pick_operand();
    x_shape_t    shape;
    int unsigned r;
    r     = $urandom_range(0, 9);
    shape = (r > 6) ? SHAPE_ANY : x_shape_t'(r);
    case (shape)
      SHAPE_SMALL:    return $urandom >> $urandom_range(1, 31);
      SHAPE_NEAR_ONE: return 32'h0100_0000 + $urandom_range(0, 512) - 32'd256;
      SHAPE_ZERO:     return 32'd0;
      SHAPE_ONE_HOT:  return 32'd1 << $urandom_range(0, 31);
      SHAPE_NEAR_MAX: return 32'hFFFF_FFFF - $urandom_range(0, 1000);
      SHAPE_ONE_FLIP: return 32'h0100_0000 ^ (32'd1 << $urandom_range(0, 23));
      default:        return $urandom;
    endcase
  endfunction

  // Offer one word and hold it until accepted; valid stays high on return.
  task automatic offer_word(logic [31:0] x);
    in_valid   <= 1'b1;
    in_x_value <= x;
    do @(negedge clk); while (!word_taken);
  endtask

  // Lower valid and wait for every outstanding result to arrive.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (words_in_flight != 0);
  endtask

  // Random operands in bursts with random gaps, sometimes none.
  task automatic random_bursts(int total);
    int sent;
    int burst;
    int gap;
    sent = 0;
    while (sent < total) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst && sent < total; i++) begin
        offer_word(pick_operand());
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // Write the stop threshold; only called with the block idle.
  task automatic write_threshold(logic [nlmn_pkg::THR_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Result back-pressure: random stall patterns, with long hold-offs now and then.
  initial begin
    int segment;
    int pct;
    int span;
    out_ready = 1'b0;
    segment   = 0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      if (segment % 25 == 1) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else begin
        case ($urandom_range(0, 4))
          0, 1:    pct = 100;
          2:       pct = 75;
          3:       pct = 40;
          default: pct = 10;
        endcase
        span = $urandom_range(8, 60);
        repeat (span) begin
          out_ready <= ($urandom_range(1, 100) <= pct);
          @(negedge clk);
        end
      end
      segment++;
    end
  end

  // Main stimulus: directed operands, then random runs over several thresholds.
  initial begin
    logic [31:0]                directed [] = '{
      32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
      32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0100_0000,
      32'h00FF_FFFF, 32'h0100_0001, 32'h02B7_E151, 32'h0001_0000,
      32'h0000_0100, 32'h1000_0000, 32'h0080_0000, 32'h0000_FFFF,
      32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0000
    };
    logic [nlmn_pkg::THR_W-1:0] thr_sets [6];
    cycle_count = 0;
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_valid    = 1'b0;
    in_x_value  = '0;
    thr_sets = '{27'd0, 27'd67108864, 27'd1, 27'd67108863,
                 27'($urandom_range(0, 67108864)), 27'd671089};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed operands at the reset threshold, then a short random run.
    foreach (directed[i]) offer_word(directed[i]);
    random_bursts(WORDS_PER_SET / 2);
    drain_results();

    // Each threshold setting gets its own random run; the sender waits for idle between.
    foreach (thr_sets[i]) begin
      write_threshold(thr_sets[i]);
      random_bursts(WORDS_PER_SET - 12);
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
